>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/fpars_pkg.sv
// Package with types and constants of the Fenwick point-add range-sum block.
package fpars_pkg;

    localparam int unsigned FPARS_MAX_ELEMENTS = 1024;
    localparam int unsigned IDX_W              = 11;
    localparam int unsigned POS_W              = 12;
    localparam int unsigned DELTA_W            = 32;
    localparam int unsigned SUM_W              = 64;
    localparam int unsigned IN_TDATA_W         = 56;
    localparam int unsigned OUT_TDATA_W        = 64;
    localparam logic [IDX_W-1:0] SIZE_RESET    = 11'd1024;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_RANGE = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_OUT
    } t_state;

endpackage

>>> rtl/fenwick_point_add_range_sum.sv
// Top level of the Fenwick point-add range-sum block.
//
// Input stream: s_axis_tuser is the opcode (add or range query), s_axis_tdata
// holds first_index, target_index and delta. Output stream: m_axis_tdata is the
// 64-bit wrapping range sum (zero for an add or a rejected item), m_axis_tuser
// is the status flag (set when target_index, or a query's first_index, lies
// outside 1..size, item dropped); a size above MAX_ELEMENTS counts as
// MAX_ELEMENTS. The size register is written through i_cfg_wr_en /
// i_cfg_wr_data. One item is worked at a time: an add makes one upward
// climb, a query two downward walks. The walks issue one read of the
// partial-sum memory per cycle, and an add writes back each updated entry in
// the cycle after its read, so the single memory read port sets the rate.
// After reset a clearing pass zeroes the memory while s_axis_tready stays
// low; the size register resets to 1024. A finished result waits in an
// output register, and the next item is accepted while it waits; a stalled
// receiver holds the block only once a second result is ready.
`include "assert_macros.svh"

module fenwick_point_add_range_sum #(
    parameter int unsigned MAX_ELEMENTS = fpars_pkg::FPARS_MAX_ELEMENTS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [fpars_pkg::IDX_W-1:0]          i_cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [10:0] first_index, [21:11] target_index, [53:22] delta, [55:54] zero
    input  logic [fpars_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] opcode
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [63:0] range_sum
    output logic [fpars_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] status
    output logic                                 m_axis_tuser
);

    localparam int unsigned AW    = $clog2(MAX_ELEMENTS);
    localparam int unsigned PW    = fpars_pkg::POS_W;
    localparam int unsigned IW    = fpars_pkg::IDX_W;
    localparam int unsigned SW    = fpars_pkg::SUM_W;
    localparam int unsigned DW    = fpars_pkg::DELTA_W;
    localparam int unsigned CW    = (AW + 1 > PW) ? AW + 1 : PW;

    fpars_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_size;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_op_add, n_op_add;
    logic          r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_first_pos, n_first_pos;
    logic [SW-1:0] r_delta, n_delta;
    logic [SW-1:0] r_acc, n_acc;
    logic          r_status, n_status;
    logic          r_rd_vld, n_rd_vld;
    logic          r_rd_sub, n_rd_sub;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_out_vld, n_out_vld;
    logic [SW-1:0] r_out_data, n_out_data;
    logic          r_out_status, n_out_status;

    logic [CW-1:0] w_n_wide;
    logic [PW-1:0] w_n;
    logic [PW-1:0] w_low;
    logic [CW-1:0] w_raddr_wide;
    logic [IW-1:0] w_first;
    logic [IW-1:0] w_target;
    logic [DW-1:0] w_delta_in;
    logic          w_in_xfer;
    logic          w_out_free;
    logic          w_target_ok;
    logic          w_first_ok;
    logic          w_walk_more;
    logic          w_re;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [SW-1:0] w_wdata;
    logic [SW-1:0] w_rdata;

    assign w_first    = s_axis_tdata[IW-1:0];
    assign w_target   = s_axis_tdata[2*IW-1:IW];
    assign w_delta_in = s_axis_tdata[2*IW+DW-1:2*IW];

    assign w_n_wide = (CW'(r_size) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(r_size);
    assign w_n      = w_n_wide[PW-1:0];
    assign w_low    = r_pos & (PW'(0) - r_pos);

    assign w_target_ok = (w_target != '0) && (PW'(w_target) <= w_n);
    assign w_first_ok  = (w_first != '0) && (PW'(w_first) <= w_n);

    assign s_axis_tready = (r_state == fpars_pkg::ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    assign w_walk_more = r_op_add ? (r_pos <= w_n) : (r_pos != '0);
    assign w_re        = (r_state == fpars_pkg::ST_WALK) && w_walk_more;
    assign w_raddr_wide = CW'(r_pos) - CW'(1);

    assign w_we    = (r_state == fpars_pkg::ST_CLEAR) || (r_rd_vld && r_op_add);
    assign w_waddr = (r_state == fpars_pkg::ST_CLEAR) ? r_clr_addr : r_rd_addr;
    assign w_wdata = (r_state == fpars_pkg::ST_CLEAR) ? '0 : w_rdata + r_delta;

    fpars_ram #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW),
        .DW    (SW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr_wide[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpars_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(MAX_ELEMENTS - 1)) begin
                    n_state = fpars_pkg::ST_IDLE;
                end
            end
            fpars_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tuser == fpars_pkg::OP_ADD) begin
                        n_state = w_target_ok ? fpars_pkg::ST_WALK : fpars_pkg::ST_OUT;
                    end else begin
                        n_state = (w_target_ok && w_first_ok) ? fpars_pkg::ST_WALK
                                                              : fpars_pkg::ST_OUT;
                    end
                end
            end
            fpars_pkg::ST_WALK: begin
                if (!w_walk_more && (r_op_add || r_phase)) begin
                    n_state = fpars_pkg::ST_OUT;
                end
            end
            fpars_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = fpars_pkg::ST_IDLE;
                end
            end
            default: n_state = fpars_pkg::ST_CLEAR;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_op_add     = r_op_add;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_first_pos  = r_first_pos;
        n_delta      = r_delta;
        n_acc        = r_acc;
        n_status     = r_status;
        n_rd_vld     = w_re;
        n_rd_sub     = r_phase;
        n_rd_addr    = w_raddr_wide[AW-1:0];
        n_out_vld    = r_out_vld;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;

        if (r_rd_vld && !r_op_add) begin
            n_acc = r_rd_sub ? r_acc - w_rdata : r_acc + w_rdata;
        end

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            fpars_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
            end
            fpars_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_op_add    = (s_axis_tuser == fpars_pkg::OP_ADD);
                    n_phase     = 1'b0;
                    n_pos       = PW'(w_target);
                    n_first_pos = PW'(w_first) - PW'(1);
                    n_delta     = {{(SW-DW){w_delta_in[DW-1]}}, w_delta_in};
                    n_acc       = '0;
                    if (s_axis_tuser == fpars_pkg::OP_ADD) begin
                        n_status = w_target_ok ? fpars_pkg::STATUS_OK
                                               : fpars_pkg::STATUS_RANGE;
                    end else begin
                        n_status = (w_target_ok && w_first_ok) ? fpars_pkg::STATUS_OK
                                                               : fpars_pkg::STATUS_RANGE;
                    end
                end
            end
            fpars_pkg::ST_WALK: begin
                if (w_walk_more) begin
                    n_pos = r_op_add ? r_pos + w_low : r_pos - w_low;
                end else if (!r_op_add && !r_phase) begin
                    n_phase = 1'b1;
                    n_pos   = r_first_pos;
                end
            end
            fpars_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_data   = r_acc;
                    n_out_status = r_status;
                end
            end
            default: n_clr_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fpars_pkg::ST_CLEAR;
            r_size     <= fpars_pkg::SIZE_RESET;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_add     <= n_op_add;
        r_phase      <= n_phase;
        r_pos        <= n_pos;
        r_first_pos  <= n_first_pos;
        r_delta      <= n_delta;
        r_acc        <= n_acc;
        r_status     <= n_status;
        r_rd_sub     <= n_rd_sub;
        r_rd_addr    <= n_rd_addr;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    `ASSERT_IMPL(a_out_from_seq, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(r_state == fpars_pkg::ST_OUT))
    `ASSERT_IMPL(a_wr_owner, i_clk, i_rst_n, w_we, (r_state == fpars_pkg::ST_CLEAR) || r_op_add)
    `ASSERT_IMPL(a_query_in_size, i_clk, i_rst_n, (r_state == fpars_pkg::ST_WALK) && !r_op_add, r_pos <= w_n)
    `ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer, r_state != fpars_pkg::ST_IDLE)

endmodule

>>> rtl/fpars_ram.sv
// Simple dual-port memory with one write port and one registered read port.
module fpars_ram #(
    parameter int unsigned DEPTH = fpars_pkg::FPARS_MAX_ELEMENTS,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned DW    = fpars_pkg::SUM_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> dv/tb_fenwick_point_add_range_sum.sv
// Self-checking testbench of the Fenwick point-add range-sum block: directed table, then random.
module tb_fenwick_point_add_range_sum;

    localparam int unsigned DIR_N      = 20;
    localparam int unsigned STALL_MAX  = 20000;
    localparam int unsigned TAIL_WAIT  = 40;
    localparam int unsigned IW         = fpars_pkg::IDX_W;

    typedef struct packed {
        logic [fpars_pkg::SUM_W-1:0] sum;
        fpars_pkg::t_status          status;
    } t_fen_result;

    typedef struct packed {
        fpars_pkg::t_opcode            op;
        logic [fpars_pkg::IDX_W-1:0]   first;
        logic [fpars_pkg::IDX_W-1:0]   target;
        logic [fpars_pkg::DELTA_W-1:0] delta;
        logic                          typed;
        logic [fpars_pkg::SUM_W-1:0]   sum;
        fpars_pkg::t_status            status;
    } t_stim_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [fpars_pkg::IDX_W-1:0]       i_cfg_wr_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [fpars_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [fpars_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              m_axis_tuser;

    logic [fpars_pkg::SUM_W-1:0] fen_store [fpars_pkg::FPARS_MAX_ELEMENTS];
    logic [fpars_pkg::IDX_W-1:0] size_reg;
    t_fen_result                 pending_results [$];
    t_stim_row                   dir_tab [DIR_N];
    int unsigned                 fail_count = 0;
    int unsigned                 stall_cycles = 0;
    int unsigned                 ready_hold = 0;
    bit                          no_idle = 1'b0;

    fenwick_point_add_range_sum i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned lowbit(input int unsigned x);
        return x & (~x + 1);
    endfunction

    function automatic int unsigned active_size();
        return (size_reg > fpars_pkg::FPARS_MAX_ELEMENTS) ? fpars_pkg::FPARS_MAX_ELEMENTS
                                                          : 32'(size_reg);
    endfunction

    function automatic logic [fpars_pkg::SUM_W-1:0] prefix_total(input int unsigned pos,
                                                                 input int unsigned n);
        logic [fpars_pkg::SUM_W-1:0] acc;
        acc = '0;
        while (pos > 0) begin
            if (pos <= n)
                acc = acc + fen_store[pos-1];
            pos = pos - lowbit(pos);
        end
        return acc;
    endfunction

    function automatic t_fen_result fenwick_step(input fpars_pkg::t_opcode op,
                                                 input logic [fpars_pkg::IDX_W-1:0] l,
                                                 input logic [fpars_pkg::IDX_W-1:0] r,
                                                 input logic [fpars_pkg::DELTA_W-1:0] d);
        t_fen_result                 res;
        int unsigned                 n;
        int unsigned                 pos;
        logic [fpars_pkg::SUM_W-1:0] amount;
        bit                          r_ok;
        n      = active_size();
        r_ok   = (r >= 1) && (r <= n);
        amount = {{(fpars_pkg::SUM_W-fpars_pkg::DELTA_W){d[fpars_pkg::DELTA_W-1]}}, d};
        res.sum    = '0;
        res.status = fpars_pkg::STATUS_OK;
        if (op == fpars_pkg::OP_ADD) begin
            if (!r_ok) begin
                res.status = fpars_pkg::STATUS_RANGE;
            end else begin
                pos = r;
                while (pos >= 1 && pos <= n) begin
                    fen_store[pos-1] = fen_store[pos-1] + amount;
                    pos = pos + lowbit(pos);
                end
            end
        end else begin
            if (!r_ok || l < 1 || l > n)
                res.status = fpars_pkg::STATUS_RANGE;
            else
                res.sum = prefix_total(r, n) - prefix_total(l - 1, n);
        end
        return res;
    endfunction

    // Count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_fen_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: sum %h status %0d", $time,
                         m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.sum) begin
                    $display("%0t range_sum mismatch: expected %h actual %h", $time,
                             want.sum, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            ready_hold    <= $urandom_range(1, 5) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input fpars_pkg::t_opcode op,
                             input logic [fpars_pkg::IDX_W-1:0] l,
                             input logic [fpars_pkg::IDX_W-1:0] r,
                             input logic [fpars_pkg::DELTA_W-1:0] d,
                             input logic typed, input t_fen_result typed_res);
        t_fen_result res;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {2'b00, d, r, l};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        res = fenwick_step(op, l, r, d);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic sender_gap();
        int unsigned k;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 5);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (k - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_size(input logic [fpars_pkg::IDX_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        size_reg      = value;
    endtask

    function automatic logic [fpars_pkg::IDX_W-1:0] pick_index(input int unsigned n);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (n > 0 && sel < 6)
            return IW'(n);
        if (n > 0 && sel < 12)
            return IW'(1);
        if (n > 0 && sel < 88)
            return IW'($urandom_range(1, n));
        return IW'($urandom_range(0, (1 << IW) - 1));
    endfunction

    function automatic logic [fpars_pkg::DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int unsigned count);
        fpars_pkg::t_opcode op;
        t_fen_result        none;
        none = '0;
        for (int unsigned k = 0; k < count; k++) begin
            if (k == count / 2)
                drain_results();
            op = ($urandom_range(0, 1) == 0) ? fpars_pkg::OP_ADD : fpars_pkg::OP_QUERY;
            sender_gap();
            send_item(op, pick_index(active_size()), pick_index(active_size()),
                      pick_delta(), 1'b0, none);
        end
    endtask

    initial begin
        t_fen_result                 typed_res;
        logic [fpars_pkg::IDX_W-1:0] phase_sizes [8];

        dir_tab = '{
            '{fpars_pkg::OP_QUERY, 11'd1,    11'd1024, 32'h0,         1'b1,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd1,    11'd1,    32'hFFFF_FFFF, 1'b1,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd0,    32'd5,         1'b1,
              64'd0, fpars_pkg::STATUS_RANGE},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd1025, 32'd5,         1'b1,
              64'd0, fpars_pkg::STATUS_RANGE},
            '{fpars_pkg::OP_ADD,   11'd2047, 11'd2047, 32'hFFFF_FFFF, 1'b1,
              64'd0, fpars_pkg::STATUS_RANGE},
            '{fpars_pkg::OP_QUERY, 11'd0,    11'd5,    32'h0,         1'b1,
              64'd0, fpars_pkg::STATUS_RANGE},
            '{fpars_pkg::OP_QUERY, 11'd5,    11'd1025, 32'h0,         1'b1,
              64'd0, fpars_pkg::STATUS_RANGE},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd1,    32'h7FFF_FFFF, 1'b1,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd1024, 32'h8000_0000, 1'b1,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd2047, 11'd3,    32'd77,        1'b1,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd512,  32'hFFFF_FFFF, 1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd1,    32'h7FFF_FFFF, 1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd1,    11'd1024, 32'h0,         1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd1024, 11'd1024, 32'hFFFF_FFFF, 1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd1,    11'd1,    32'h0,         1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd600,  11'd10,   32'h0,         1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd513,  11'd512,  32'h0,         1'b1,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd0,    11'd777,  32'h5555_AAAA, 1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_ADD,   11'd1365, 11'd333,  32'hAAAA_5555, 1'b0,
              64'd0, fpars_pkg::STATUS_OK},
            '{fpars_pkg::OP_QUERY, 11'd300,  11'd800,  32'h0,         1'b0,
              64'd0, fpars_pkg::STATUS_OK}
        };

        for (int k = 0; k < fpars_pkg::FPARS_MAX_ELEMENTS; k++)
            fen_store[k] = '0;
        size_reg = fpars_pkg::SIZE_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            typed_res.sum    = dir_tab[k].sum;
            typed_res.status = dir_tab[k].status;
            sender_gap();
            send_item(dir_tab[k].op, dir_tab[k].first, dir_tab[k].target, dir_tab[k].delta,
                      dir_tab[k].typed, typed_res);
        end

        phase_sizes = '{11'd1, 11'd2047, 11'd0, 11'd1024,
                        11'($urandom_range(2, 1023)), 11'd2,
                        11'($urandom_range(1025, 2046)), 11'd1024};
        for (int p = 0; p < 8; p++) begin
            set_size(phase_sizes[p]);
            if (p == 7)
                no_idle = 1'b1;
            run_random((phase_sizes[p] == 0) ? 40 : 235);
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
